### rtl/tmdr_pkg.sv
// Shared types and constants for the tile map renderer.
`default_nettype none

package tmdr_pkg;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_DEFINE  = 2'd1,
    MODE_PUT     = 2'd2,
    MODE_PRESENT = 2'd3
  } mode_e_t;

  // One input item
  typedef struct packed {
    mode_e_t     mode;
    logic [7:0]  tile_x;
    logic [7:0]  tile_y;
    logic [7:0]  tile_id;
    logic [2:0]  bitmap_row;
    logic [7:0]  row_bits;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last_pixel;
    logic        flush;
  } out_item_t;

  // Queue between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic     valid;
    in_item_t head;
  } q_status_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PUT,
    BK_SCAN,
    BK_ROW,
    BK_COL,
    BK_CELL,
    BK_EMIT,
    BK_FLUSH
  } bk_state_t;

  localparam int TILE_COUNT = 256;
  localparam logic [5:0] LAST_PIXEL_IDX = 6'd63;

endpackage

`default_nettype wire

### rtl/tmdr_front.sv
// Front end: accepts input items and drops puts that fall outside the map.
`default_nettype none

module tmdr_front #(
  parameter int MAP_COLUMNS = 40,
  parameter int MAP_ROWS    = 30
) (
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire tmdr_pkg::in_item_t cmd,
  input  wire logic               q_full,
  output logic                    push,
  output tmdr_pkg::in_item_t      push_data
);

  logic out_of_map;

  // Classify: a put outside the map changes nothing and never enters the queue
  always_comb begin
    out_of_map = (cmd.mode == tmdr_pkg::MODE_PUT) &&
                 ((cmd.tile_x >= 8'(MAP_COLUMNS)) || (cmd.tile_y >= 8'(MAP_ROWS)));
  end

  // Hold the sender while the queue is full
  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full && !out_of_map;
  assign push_data = cmd;

endmodule

`default_nettype wire

### rtl/tmdr_queue.sv
// Short command queue between front end and back end.
`default_nettype none

module tmdr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tmdr_pkg::in_item_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output tmdr_pkg::q_status_t     status
);

  tmdr_pkg::in_item_t entries [tmdr_pkg::Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full         = (count == 2'(tmdr_pkg::Q_DEPTH));
  assign status.valid = (count != 2'd0);
  assign status.head  = entries[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tmdr_back.sv
// Back end: map and tile stores, dirty search and pixel emission.
`default_nettype none

module tmdr_back #(
  parameter int MAP_COLUMNS = 40,
  parameter int MAP_ROWS    = 30
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tmdr_pkg::q_status_t status,
  output logic                     pop,
  output logic                     pix_valid,
  input  wire logic                pix_stall,
  output tmdr_pkg::out_item_t      pix
);

  localparam int COL_W      = (MAP_COLUMNS > 1) ? $clog2(MAP_COLUMNS) : 1;
  localparam int ROW_W      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int NCHUNK     = (MAP_COLUMNS + 7) / 8;
  localparam int CHUNK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W      = NCHUNK * 8;
  localparam int PCOL_W     = CHUNK_W + 3;
  localparam int CELL_AW    = ROW_W + COL_W;
  localparam int CELL_DEPTH = 1 << CELL_AW;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAP_ROWS - 1);

  // Stores
  logic [2*MAP_COLUMNS-1:0] row_mem  [MAP_ROWS];
  logic [7:0]               cell_mem [CELL_DEPTH];
  logic [63:0]              bmp_mem  [tmdr_pkg::TILE_COUNT];
  logic [15:0]              fg_mem   [tmdr_pkg::TILE_COUNT];
  logic [15:0]              bg_mem   [tmdr_pkg::TILE_COUNT];

  // Read data registers
  logic [2*MAP_COLUMNS-1:0] row_rd;
  logic [7:0]               cell_rd;
  logic [63:0]              bmp_rd;
  logic [15:0]              fg_rd;
  logic [15:0]              bg_rd;

  // Control and working registers
  tmdr_pkg::bk_state_t     state;
  tmdr_pkg::bk_state_t     state_next;
  tmdr_pkg::in_item_t      cmd_q;
  logic [ROW_W-1:0]        cur_row;
  logic [COL_W-1:0]        cur_col;
  logic [CHUNK_W-1:0]      chunk;
  logic [5:0]              pix_cnt;
  logic [PAD_W-1:0]        dirty_pad;
  logic [MAP_COLUMNS-1:0]  valid_word;
  logic                    cell_ok;
  logic                    tile_ok_q;
  logic [MAP_ROWS-1:0]     row_stale;
  logic [MAP_ROWS-1:0]     row_dirty;
  logic                    fill_dirty;
  logic [tmdr_pkg::TILE_COUNT-1:0] tile_ok;

  // Combinational control
  logic                    slot_free;
  logic                    row_rd_en;
  logic [ROW_W-1:0]        row_rd_addr;
  logic                    row_wr_en;
  logic [2*MAP_COLUMNS-1:0] row_wr_data;
  logic                    cell_rd_en;
  logic [CELL_AW-1:0]      cell_rd_addr;
  logic                    cell_wr_en;
  logic                    tile_rd_en;
  logic [7:0]              tile_rd_id;
  logic                    load_pix;
  logic                    load_flush;
  logic [MAP_COLUMNS-1:0]  eff_valid;
  logic [MAP_COLUMNS-1:0]  eff_dirty;
  logic [COL_W-1:0]        put_col;
  logic [MAP_COLUMNS-1:0]  put_mask;
  logic [7:0]              put_old_id;
  logic                    put_change;
  logic [7:0]              chunk_bits;
  logic [2:0]              hit_idx;
  logic                    hit;
  logic [PCOL_W-1:0]       hit_col_pad;
  logic [COL_W-1:0]        hit_col;
  logic [MAP_COLUMNS-1:0]  hit_mask;
  logic [MAP_COLUMNS-1:0]  new_dirty;
  logic                    pix_bit;
  tmdr_pkg::out_item_t     pix_data;

  // Resolve a row word: a stale row reads as the state of the last bulk reset or clear
  always_comb begin
    eff_valid  = row_stale[cur_row] ? '0 : row_rd[2*MAP_COLUMNS-1:MAP_COLUMNS];
    eff_dirty  = row_stale[cur_row] ? {MAP_COLUMNS{fill_dirty}} : row_rd[MAP_COLUMNS-1:0];
    put_col    = cmd_q.tile_x[COL_W-1:0];
    put_mask   = MAP_COLUMNS'(1) << put_col;
    put_old_id = (|(eff_valid & put_mask)) ? cell_rd : 8'd0;
    put_change = (put_old_id != cmd_q.tile_id);
  end

  // Find the first dirty column inside the current chunk of eight
  always_comb begin
    chunk_bits = dirty_pad[{chunk, 3'b000} +: 8];
    hit        = |chunk_bits;
    hit_idx    = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (chunk_bits[i]) begin
        hit_idx = 3'(i);
      end
    end
    hit_col_pad = {chunk, hit_idx};
    hit_col     = hit_col_pad[COL_W-1:0];
    hit_mask    = MAP_COLUMNS'(1) << hit_col;
    new_dirty   = dirty_pad[MAP_COLUMNS-1:0] & ~hit_mask;
  end

  // Build the next pixel from the fetched tile
  always_comb begin
    pix_bit              = bmp_rd[{pix_cnt[5:3], ~pix_cnt[2:0]}];
    pix_data.pixel_x     = 9'({cur_col, pix_cnt[2:0]});
    pix_data.pixel_y     = 8'({cur_row, pix_cnt[5:3]});
    pix_data.pixel_color = tile_ok_q ? (pix_bit ? fg_rd : bg_rd) : 16'd0;
    pix_data.last_pixel  = (pix_cnt == tmdr_pkg::LAST_PIXEL_IDX);
    pix_data.flush       = 1'b0;
  end

  assign slot_free = !pix_valid || !pix_stall;

  // Sequencer: next state and store controls
  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    row_rd_en    = 1'b0;
    row_rd_addr  = cur_row;
    row_wr_en    = 1'b0;
    row_wr_data  = {eff_valid | put_mask, eff_dirty | put_mask};
    cell_rd_en   = 1'b0;
    cell_rd_addr = {cur_row, hit_col};
    cell_wr_en   = 1'b0;
    tile_rd_en   = 1'b0;
    tile_rd_id   = cell_ok ? cell_rd : 8'd0;
    load_pix     = 1'b0;
    load_flush   = 1'b0;
    unique case (state)
      tmdr_pkg::BK_IDLE: begin
        if (status.valid) begin
          pop = 1'b1;
          unique case (status.head.mode)
            tmdr_pkg::MODE_CLEAR,
            tmdr_pkg::MODE_DEFINE: state_next = tmdr_pkg::BK_IDLE;
            tmdr_pkg::MODE_PUT: begin
              row_rd_en    = 1'b1;
              row_rd_addr  = status.head.tile_y[ROW_W-1:0];
              cell_rd_en   = 1'b1;
              cell_rd_addr = {status.head.tile_y[ROW_W-1:0],
                              status.head.tile_x[COL_W-1:0]};
              state_next   = tmdr_pkg::BK_PUT;
            end
            tmdr_pkg::MODE_PRESENT: state_next = tmdr_pkg::BK_SCAN;
            default: state_next = tmdr_pkg::BK_IDLE;
          endcase
        end
      end
      tmdr_pkg::BK_PUT: begin
        if (put_change) begin
          row_wr_en  = 1'b1;
          cell_wr_en = 1'b1;
        end
        state_next = tmdr_pkg::BK_IDLE;
      end
      tmdr_pkg::BK_SCAN: begin
        if (row_dirty[cur_row]) begin
          row_rd_en  = 1'b1;
          state_next = tmdr_pkg::BK_ROW;
        end else if (cur_row == LAST_ROW) begin
          state_next = tmdr_pkg::BK_FLUSH;
        end
      end
      tmdr_pkg::BK_ROW: begin
        state_next = tmdr_pkg::BK_COL;
      end
      tmdr_pkg::BK_COL: begin
        if (hit) begin
          cell_rd_en  = 1'b1;
          row_wr_en   = 1'b1;
          row_wr_data = {valid_word, new_dirty};
          state_next  = tmdr_pkg::BK_CELL;
        end
      end
      tmdr_pkg::BK_CELL: begin
        tile_rd_en = 1'b1;
        state_next = tmdr_pkg::BK_EMIT;
      end
      tmdr_pkg::BK_EMIT: begin
        if (slot_free) begin
          load_pix = 1'b1;
          if (pix_cnt == tmdr_pkg::LAST_PIXEL_IDX) begin
            state_next = tmdr_pkg::BK_IDLE;
          end
        end
      end
      tmdr_pkg::BK_FLUSH: begin
        if (slot_free) begin
          load_flush = 1'b1;
          state_next = tmdr_pkg::BK_IDLE;
        end
      end
      default: state_next = tmdr_pkg::BK_IDLE;
    endcase
  end

  // Map stores: row words and cell ids
  always_ff @(posedge clk) begin
    if (row_rd_en) begin
      row_rd <= row_mem[row_rd_addr];
    end
    if (row_wr_en) begin
      row_mem[cur_row] <= row_wr_data;
    end
    if (cell_rd_en) begin
      cell_rd <= cell_mem[cell_rd_addr];
    end
    if (cell_wr_en) begin
      cell_mem[{cur_row, put_col}] <= cmd_q.tile_id;
    end
  end

  // Tile stores: a first write to a tile fills its whole bitmap
  always_ff @(posedge clk) begin
    if (pop && status.head.mode == tmdr_pkg::MODE_CLEAR) begin
      fg_mem[0] <= status.head.fg_color;
      bg_mem[0] <= status.head.fg_color;
      if (!tile_ok[0]) begin
        bmp_mem[0] <= 64'd0;
      end
    end
    if (pop && status.head.mode == tmdr_pkg::MODE_DEFINE) begin
      fg_mem[status.head.tile_id] <= status.head.fg_color;
      bg_mem[status.head.tile_id] <= status.head.bg_color;
      if (tile_ok[status.head.tile_id]) begin
        bmp_mem[status.head.tile_id][{status.head.bitmap_row, 3'b000} +: 8] <=
          status.head.row_bits;
      end else begin
        bmp_mem[status.head.tile_id] <=
          64'(status.head.row_bits) << {status.head.bitmap_row, 3'b000};
      end
    end
    if (tile_rd_en) begin
      bmp_rd <= bmp_mem[tile_rd_id];
      fg_rd  <= fg_mem[tile_rd_id];
      bg_rd  <= bg_mem[tile_rd_id];
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q <= status.head;
    end
    if (state == tmdr_pkg::BK_ROW) begin
      dirty_pad  <= PAD_W'(eff_dirty);
      valid_word <= eff_valid;
    end
    if (state == tmdr_pkg::BK_COL && hit) begin
      cur_col <= hit_col;
      cell_ok <= |(valid_word & hit_mask);
    end
    if (tile_rd_en) begin
      tile_ok_q <= tile_ok[tile_rd_id];
    end
    if (load_pix) begin
      pix <= pix_data;
    end else if (load_flush) begin
      pix <= '{pixel_x: 9'd0, pixel_y: 8'd0, pixel_color: 16'd0,
               last_pixel: 1'b0, flush: 1'b1};
    end
  end

  // State register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tmdr_pkg::BK_IDLE;
      cur_row    <= '0;
      chunk      <= '0;
      pix_cnt    <= 6'd0;
      row_stale  <= '1;
      row_dirty  <= '0;
      fill_dirty <= 1'b0;
      tile_ok    <= '0;
      pix_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // Track map and tile bookkeeping
      if (pop) begin
        unique case (status.head.mode)
          tmdr_pkg::MODE_CLEAR: begin
            row_stale  <= '1;
            row_dirty  <= '1;
            fill_dirty <= 1'b1;
            tile_ok[0] <= 1'b1;
          end
          tmdr_pkg::MODE_DEFINE: tile_ok[status.head.tile_id] <= 1'b1;
          tmdr_pkg::MODE_PUT:    cur_row <= status.head.tile_y[ROW_W-1:0];
          tmdr_pkg::MODE_PRESENT: cur_row <= '0;
          default: cur_row <= cur_row;
        endcase
      end
      if (state == tmdr_pkg::BK_PUT && put_change) begin
        row_stale[cur_row] <= 1'b0;
        row_dirty[cur_row] <= 1'b1;
      end
      // Advance the row scan
      if (state == tmdr_pkg::BK_SCAN && !row_dirty[cur_row] && cur_row != LAST_ROW) begin
        cur_row <= cur_row + 1'b1;
      end
      if (state == tmdr_pkg::BK_ROW) begin
        chunk <= '0;
      end
      // Advance the column scan or retire the found cell
      if (state == tmdr_pkg::BK_COL) begin
        if (hit) begin
          row_stale[cur_row] <= 1'b0;
          row_dirty[cur_row] <= |new_dirty;
        end else begin
          chunk <= chunk + 1'b1;
        end
      end
      if (state == tmdr_pkg::BK_CELL) begin
        pix_cnt <= 6'd0;
      end else if (load_pix) begin
        pix_cnt <= pix_cnt + 6'd1;
      end
      // Output register: load a result or drop it once transferred
      if (load_pix || load_flush) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tile_map_dirty_renderer.sv
// Top level of the tile map renderer with per-cell dirty marks.
//
// Usage: items enter on cmd (valid/stall); a transfer happens when cmd_valid
// is high and cmd_stall is low. Results leave on pix with the same rule.
// Clear, define and put update the tile and map stores and give no result.
// Present finds the first dirty cell in row-major order, clears its mark and
// emits its 64 pixels, left to right and top to bottom, the last one flagged
// by last_pixel; with no dirty cell it emits a single result with flush set.
// Back end steps: clear and define are done as they are popped; put reads
// the row word and cell, then writes both back if the id changes. Present
// scans rows, one per cycle, up to MAP_ROWS, loads the dirty row word, scans
// column chunks of eight, one per cycle, up to ceil(MAP_COLUMNS/8), fetches
// the tile, then emits pixels at one per cycle while the output is not stalled.
// A two-entry queue lets the front accept items while the back end works.
// Reset empties the queue and output register; all stores read as zero
// after reset with no clearing pass. When pix_stall is high a valid
// result holds and pixel emission pauses.
`default_nettype none

module tile_map_dirty_renderer #(
  parameter int MAP_COLUMNS = 40,
  parameter int MAP_ROWS    = 30
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire tmdr_pkg::in_item_t  cmd,
  output logic                     pix_valid,
  input  wire logic                pix_stall,
  output tmdr_pkg::out_item_t      pix
);

  logic                q_full;
  logic                push;
  logic                pop;
  tmdr_pkg::in_item_t  push_data;
  tmdr_pkg::q_status_t status;

  tmdr_front #(
    .MAP_COLUMNS(MAP_COLUMNS),
    .MAP_ROWS   (MAP_ROWS)
  ) u_front (
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  tmdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .status   (status)
  );

  tmdr_back #(
    .MAP_COLUMNS(MAP_COLUMNS),
    .MAP_ROWS   (MAP_ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .pop      (pop),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix)
  );

endmodule

`default_nettype wire
